[hw/rtl/asa_pkg.sv]
// Shared types and constants for the ADC scan averager.
`timescale 1ns / 1ps
package asa_pkg;

  localparam int SAMPLE_W = 10;
  localparam int CHAN_W   = 4;
  localparam int SUM_W    = 16;
  localparam int REF_W    = 2;
  localparam int MUXCH_W  = 6;
  localparam int MUX_W    = REF_W + MUXCH_W;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [CHAN_W-1:0]  REMAP_START  = 4'd9;
  localparam logic [MUXCH_W-1:0] REMAP_OFFSET = 6'd5;
  localparam logic [REF_W-1:0]   REF_RESET    = 2'd1;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]   channel;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] read_value;
    logic                ready_res;
    logic [MUX_W-1:0]    mux_setting;
    logic                value_stored;
  } out_item_t;

  typedef struct packed {
    logic                en;
    logic [CHAN_W-1:0]   addr;
    logic [SAMPLE_W-1:0] data;
  } tbl_wr_t;

endpackage

[hw/rtl/asa_div.sv]
// Divide a window sum by the constant window length via reciprocal multiply.
`timescale 1ns / 1ps
module asa_div #(
  parameter int DIVISOR = 20
) (
  input  logic [asa_pkg::SUM_W-1:0]    dividend,
  output logic [asa_pkg::SAMPLE_W-1:0] quotient
);
  import asa_pkg::*;

  localparam int SHIFT  = SUM_W + $clog2(DIVISOR);
  localparam int MULT_W = SUM_W + 1;
  localparam int PROD_W = SUM_W + MULT_W;
  localparam logic [MULT_W-1:0] MULT_C = MULT_W'(((2 ** SHIFT) + DIVISOR - 1) / DIVISOR);

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] shifted;

  assign prod     = PROD_W'(dividend) * PROD_W'(MULT_C);
  assign shifted  = prod >> SHIFT;
  assign quotient = shifted[SAMPLE_W-1:0];

endmodule

[hw/rtl/asa_table.sv]
// Per-channel average table with one write port and one read port.
`timescale 1ns / 1ps
module asa_table #(
  parameter int NUM_CHANNELS = 11
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  asa_pkg::tbl_wr_t             wr,
  input  logic [asa_pkg::CHAN_W-1:0]   rd_addr,
  output logic [asa_pkg::SAMPLE_W-1:0] rd_data
);
  import asa_pkg::*;

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [SAMPLE_W-1:0] mem_r [NUM_CHANNELS];

  logic wr_ok;
  logic rd_ok;

  assign wr_ok = {1'b0, wr.addr} < (CHAN_W+1)'(NUM_CHANNELS);
  assign rd_ok = {1'b0, rd_addr} < (CHAN_W+1)'(NUM_CHANNELS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        mem_r[i] <= '0;
      end
    end else if (wr.en && wr_ok) begin
      mem_r[wr.addr[IDX_W-1:0]] <= wr.data;
    end
  end

  assign rd_data = rd_ok ? mem_r[rd_addr[IDX_W-1:0]] : '0;

endmodule

[hw/rtl/adc_scan_averager.sv]
// Top level of the ADC scan averager: item registers and scan control.
//
// Usage:
//   in_item carries one request: a conversion tick with its sample, a start
//   request, or a channel read. Each accepted item yields exactly one result
//   item on out_item, in order. cfg_we / cfg_wdata write the reference
//   select code; the user must do so only while the block idles (not enforced).
// Timing:
//   An item accepted into the input register is processed into the output
//   register once the output may advance; its result is valid from then on.
//   One item per cycle is sustained if out_ready is high; the add, reciprocal
//   multiply and table write of a tick sit between input and output registers.
// Reset:
//   rst_n (synchronous, active low) clears the table, the sum and the scan
//   state, loads the window counter and sets the reference code to 1.
// Stall:
//   While out_ready is low the result holds; the input register still takes
//   one more item if it is empty, then in_ready drops until the output drains.
`timescale 1ns / 1ps
module adc_scan_averager #(
  parameter int NUM_CHANNELS    = 11,
  parameter int SAMPLES_PER_AVG = 20
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  asa_pkg::in_item_t          in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output asa_pkg::out_item_t         out_item,
  input  logic                       cfg_we,
  input  logic [asa_pkg::REF_W-1:0]  cfg_wdata
);
  import asa_pkg::*;

  localparam int CNT_W = $clog2(SAMPLES_PER_AVG + 1);

  logic       in_v_r;
  in_item_t   in_item_r;
  logic       out_v_r;
  out_item_t  out_item_r;
  logic       advance;
  logic       proc;

  logic [REF_W-1:0]  ref_r;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              phase_r, phase_nxt;
  logic [CHAN_W-1:0] idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic              work_r, work_nxt;
  logic              done_r, done_nxt;

  logic [SUM_W-1:0]    sum_add;
  logic [CNT_W-1:0]    cnt_dec;
  logic [CHAN_W:0]     idx_inc;
  logic [SAMPLE_W-1:0] avg;
  logic [SAMPLE_W-1:0] rd_data;
  logic [MUXCH_W-1:0]  mux_ch;
  logic                stored;
  tbl_wr_t             tbl_wr;
  out_item_t           result;

  assign advance   = !out_v_r || out_ready;
  assign in_ready  = !in_v_r || advance;
  assign proc      = in_v_r && advance;
  assign out_valid = out_v_r;
  assign out_item  = out_item_r;

  assign sum_add = sum_r + (phase_r ? SUM_W'(in_item_r.sample) : '0);
  assign cnt_dec = (cnt_r != '0) ? cnt_r - CNT_W'(1) : '0;
  assign idx_inc = {1'b0, idx_r} + (CHAN_W+1)'(1);

  asa_div #(
    .DIVISOR (SAMPLES_PER_AVG)
  ) u_div (
    .dividend (sum_add),
    .quotient (avg)
  );

  asa_table #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (tbl_wr),
    .rd_addr (in_item_r.channel),
    .rd_data (rd_data)
  );

  always_comb begin
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    pend_nxt  = pend_r;
    work_nxt  = work_r;
    done_nxt  = done_r;
    stored    = 1'b0;
    tbl_wr.en   = 1'b0;
    tbl_wr.addr = idx_r;
    tbl_wr.data = avg;
    case (in_item_r.req_type)
      REQ_TICK: begin
        sum_nxt = sum_add;
        cnt_nxt = cnt_dec;
        if (cnt_dec == '0) begin
          cnt_nxt = CNT_W'(SAMPLES_PER_AVG);
          if (phase_r) begin
            stored    = 1'b1;
            tbl_wr.en = proc;
            sum_nxt   = '0;
            phase_nxt = 1'b0;
            if (idx_inc >= (CHAN_W+1)'(NUM_CHANNELS)) begin
              idx_nxt = '0;
              if (work_r) begin
                done_nxt = 1'b1;
                work_nxt = 1'b0;
              end
              if (pend_r) begin
                work_nxt = 1'b1;
                pend_nxt = 1'b0;
              end
            end else begin
              idx_nxt = idx_inc[CHAN_W-1:0];
            end
          end else begin
            phase_nxt = 1'b1;
          end
        end
      end
      REQ_START: begin
        work_nxt = 1'b0;
        done_nxt = 1'b0;
        pend_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (idx_nxt < REMAP_START) begin
      mux_ch = MUXCH_W'(idx_nxt);
    end else begin
      mux_ch = MUXCH_W'(idx_nxt) + REMAP_OFFSET;
    end
    result.read_value   = (in_item_r.req_type == REQ_READ) ? rd_data : '0;
    result.ready_res    = done_nxt;
    result.mux_setting  = {ref_r, mux_ch};
    result.value_stored = stored;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      ref_r   <= REF_RESET;
      sum_r   <= '0;
      cnt_r   <= CNT_W'(SAMPLES_PER_AVG);
      phase_r <= 1'b0;
      idx_r   <= '0;
      pend_r  <= 1'b0;
      work_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        ref_r <= cfg_wdata;
      end
      if (in_valid && in_ready) begin
        in_v_r <= 1'b1;
      end else if (advance) begin
        in_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r <= in_v_r;
      end
      if (proc) begin
        sum_r   <= sum_nxt;
        cnt_r   <= cnt_nxt;
        phase_r <= phase_nxt;
        idx_r   <= idx_nxt;
        pend_r  <= pend_nxt;
        work_r  <= work_nxt;
        done_r  <= done_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
    if (proc) begin
      out_item_r <= result;
    end
  end

endmodule
